// ----- rtl/weighted_range_sum_engine_assert.svh -----
// ----------------------------------------------------------------------------
// weighted range sum engine assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANGE_SUM_ENGINE_ASSERT_SVH
`define WEIGHTED_RANGE_SUM_ENGINE_ASSERT_SVH

// same-cycle implication
`define WRSE_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WRSE_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/wrse_pkg.sv -----
// ----------------------------------------------------------------------------
// wrse_pkg
// field widths, stream packing and request kinds of the weighted range sum engine
// ----------------------------------------------------------------------------
package wrse_pkg;

	localparam int ELEM_W     = 32;
	localparam int RANGE_W    = 11;
	localparam int SUM_W      = 64;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 64;
	localparam int ELEM_LSB   = 0;
	localparam int FIRST_LSB  = ELEM_LSB + ELEM_W;
	localparam int LAST_LSB   = FIRST_LSB + RANGE_W;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

endpackage

// ----- rtl/wrse_queue.sv -----
// ----------------------------------------------------------------------------
// wrse_queue
// short fifo that decouples request classification from execution
// ----------------------------------------------------------------------------
`include "weighted_range_sum_engine_assert.svh"

module wrse_queue
	import wrse_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty  = (count_q != '0);
	assign head_entry = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	`WRSE_ASSERT_NOW(a_queue_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
	`WRSE_ASSERT_NOW(a_push_room, push, !full, "push into full queue")

endmodule

// ----- rtl/wrse_front.sv -----
// ----------------------------------------------------------------------------
// wrse_front
// accepts requests, validates queries, keeps running prefix sums
// ----------------------------------------------------------------------------
`include "weighted_range_sum_engine_assert.svh"

module wrse_front
	import wrse_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024,
	localparam int CW = $clog2(MAX_ELEMENTS + 1),
	localparam int PW = CW + 32,
	localparam int WW = 2 * CW + 31,
	localparam int EW = 2 + 2 * RANGE_W + CW + PW + WW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 q_full,
	output logic                 push,
	output logic [EW-1:0]        push_entry
);

	localparam int XW = (CW > RANGE_W) ? CW : RANGE_W;

	typedef struct packed {
		logic               is_query;
		logic               bad;
		logic [RANGE_W-1:0] first;
		logic [RANGE_W-1:0] last;
		logic [CW-1:0]      addr;
		logic [PW-1:0]      psum;
		logic [WW-1:0]      wsum;
	} entry_t;

	logic [CW-1:0]        count_q;
	logic signed [PW-1:0] psum_q;
	logic signed [WW-1:0] wsum_q;

	mode_t                mode;
	logic signed [31:0]   elem;
	logic [RANGE_W-1:0]   first;
	logic [RANGE_W-1:0]   last;
	logic                 accept;
	logic                 store_full;
	logic                 bad;
	logic                 load_ok;
	logic [CW-1:0]        count_next;
	logic signed [PW-1:0] psum_next;
	logic signed [CW+32:0] wprod;
	logic signed [WW-1:0] wsum_next;
	entry_t               entry;

	assign mode  = mode_t'(s_tuser);
	assign elem  = $signed(s_tdata[FIRST_LSB-1:ELEM_LSB]);
	assign first = s_tdata[LAST_LSB-1:FIRST_LSB];
	assign last  = s_tdata[LAST_LSB+RANGE_W-1:LAST_LSB];

	assign s_tready   = !q_full;
	assign accept     = s_tvalid && s_tready;
	assign store_full = (count_q == CW'(MAX_ELEMENTS));
	assign bad        = (first == '0) || (first > last) || (XW'(last) > XW'(count_q));
	assign load_ok    = accept && (mode == MODE_LOAD) && !store_full;

	assign count_next = count_q + 1'b1;
	assign psum_next  = psum_q + PW'(elem);
	assign wprod      = elem * $signed({1'b0, count_next});
	assign wsum_next  = wsum_q + WW'(wprod);

	always_comb begin
		entry.is_query = (mode == MODE_QUERY);
		entry.bad      = bad;
		entry.first    = first;
		entry.last     = last;
		entry.addr     = count_next;
		entry.psum     = psum_next;
		entry.wsum     = wsum_next;
	end

	assign push       = accept && ((mode == MODE_QUERY) || !store_full);
	assign push_entry = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			psum_q  <= '0;
			wsum_q  <= '0;
		end else if (load_ok) begin
			count_q <= count_next;
			psum_q  <= psum_next;
			wsum_q  <= wsum_next;
		end
	end

	`WRSE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ELEMENTS), "element count overrun")
	`WRSE_ASSERT_NEXT(a_full_drop, accept && (mode == MODE_LOAD) && store_full,
		$stable(count_q) && $stable(psum_q), "load into full store changed state")

endmodule

// ----- rtl/wrse_back.sv -----
// ----------------------------------------------------------------------------
// wrse_back
// prefix stores and the query pipeline: read, difference, scale, result
// ----------------------------------------------------------------------------
`include "weighted_range_sum_engine_assert.svh"

module wrse_back
	import wrse_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024,
	localparam int CW = $clog2(MAX_ELEMENTS + 1),
	localparam int PW = CW + 32,
	localparam int WW = 2 * CW + 31,
	localparam int EW = 2 + 2 * RANGE_W + CW + PW + WW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic [EW-1:0]        q_entry,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser
);

	localparam int MW = PW + RANGE_W + 1;

	typedef struct packed {
		logic               is_query;
		logic               bad;
		logic [RANGE_W-1:0] first;
		logic [RANGE_W-1:0] last;
		logic [CW-1:0]      addr;
		logic [PW-1:0]      psum;
		logic [WW-1:0]      wsum;
	} entry_t;

	logic [PW-1:0] pmem [0:MAX_ELEMENTS];
	logic [WW-1:0] wmem [0:MAX_ELEMENTS];

	entry_t             head;
	logic               adv;
	logic               do_wr;
	logic               do_rd;
	logic [RANGE_W-1:0] head_fm1;

	logic               valid_s1;
	logic               bad_s1;
	logic               zl_s1;
	logic [RANGE_W-1:0] fm1_s1;
	logic [PW-1:0]      p_hi_s1;
	logic [PW-1:0]      p_lo_s1;
	logic [WW-1:0]      w_hi_s1;
	logic [WW-1:0]      w_lo_s1;

	logic                 valid_s2;
	logic                 bad_s2;
	logic [RANGE_W-1:0]   fm1_s2;
	logic signed [PW-1:0] pdiff_s2;
	logic signed [WW-1:0] wdiff_s2;

	logic                 valid_s3;
	logic                 bad_s3;
	logic signed [MW-1:0] prod_s3;
	logic signed [WW-1:0] wdiff_s3;

	logic                    m_tvalid_q;
	logic                    bad_q;
	logic signed [SUM_W-1:0] sum_q;

	assign head     = entry_t'(q_entry);
	assign adv      = !m_tvalid_q || m_tready;
	assign pop      = adv && q_valid;
	assign do_wr    = pop && !head.is_query;
	assign do_rd    = pop && head.is_query && !head.bad;
	assign head_fm1 = head.first - 1'b1;

	// stores: one write port for loads, two read ports for queries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			pmem[head.addr] <= head.psum;
			wmem[head.addr] <= head.wsum;
		end
		if (do_rd) begin
			p_hi_s1 <= pmem[CW'(head.last)];
			p_lo_s1 <= pmem[CW'(head_fm1)];
			w_hi_s1 <= wmem[CW'(head.last)];
			w_lo_s1 <= wmem[CW'(head_fm1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			valid_s1   <= pop && head.is_query;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			m_tvalid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1 <= head.bad;
			zl_s1  <= (head.first == RANGE_W'(1));
			fm1_s1 <= head_fm1;

			// entry zero of both stores is never written; zero stands in for it
			bad_s2   <= bad_s1;
			fm1_s2   <= fm1_s1;
			pdiff_s2 <= $signed(p_hi_s1) - (zl_s1 ? '0 : $signed(p_lo_s1));
			wdiff_s2 <= $signed(w_hi_s1) - (zl_s1 ? '0 : $signed(w_lo_s1));

			bad_s3   <= bad_s2;
			prod_s3  <= pdiff_s2 * $signed({1'b0, fm1_s2});
			wdiff_s3 <= wdiff_s2;

			bad_q <= bad_s3;
			sum_q <= bad_s3 ? '0 : (SUM_W'(wdiff_s3) - SUM_W'(prod_s3));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = sum_q;
	assign m_tuser  = bad_q;

	`WRSE_ASSERT_NOW(a_pop_has_data, pop, q_valid, "pop from empty queue")

endmodule

// ----- rtl/weighted_range_sum_engine.sv -----
// ----------------------------------------------------------------------------
// weighted_range_sum_engine
// appends signed elements and answers index-weighted range sum queries
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s        in   element_value, range_first, range_last  mode
// m        out  weighted_sum                            bad_query
//
// one request per cycle sustained while m does not stall; loads give no result
// a query result passes through the four-entry queue, then the store read,
// difference, scale and result registers before it is valid on m
// reset is asynchronous; stores are not cleared, entry zero is taken as zero
// an m stall freezes the back pipeline; s stalls only once the queue fills
// ----------------------------------------------------------------------------
`include "weighted_range_sum_engine_assert.svh"

module weighted_range_sum_engine
	import wrse_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // element_value, range_first, range_last, pad
	input  logic                 s_tuser,  // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // weighted_sum
	output logic                 m_tuser   // bad_query
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int PW = CW + 32;
	localparam int WW = 2 * CW + 31;
	localparam int EW = 2 + 2 * RANGE_W + CW + PW + WW;

	logic          q_full;
	logic          q_push;
	logic [EW-1:0] q_push_entry;
	logic          q_pop;
	logic          q_not_empty;
	logic [EW-1:0] q_head;

	wrse_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	wrse_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head_entry (q_head)
	);

	wrse_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_not_empty),
		.q_entry  (q_head),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`WRSE_ASSERT_NOW(a_bad_is_zero, m_tvalid && m_tuser, m_tdata == '0, "rejected query with sum")

endmodule
